// ===== rtl/core/rpbp_pkg.sv =====
// Shared types, codes and layout tables of the IS-IS PDU byte parser.
package rpbp_pkg;

  // Address sizes used by the fixed layouts.
  localparam int unsigned SYSTEM_ID_BYTES = 6;
  localparam int unsigned LAN_ID_BYTES    = 7;

  // Length of the common header, in bytes.
  localparam int unsigned COMMON_HDR_LEN = 8;

  // Depth of the queue between the front and the back, and its pointer and count widths.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned NUM_KINDS  = 5;
  localparam int unsigned NUM_FIELDS = 6;

  typedef enum logic [2:0] {
    KIND_LAN_HELLO = 3'd0,
    KIND_P2P_HELLO = 3'd1,
    KIND_LSP       = 3'd2,
    KIND_CSNP      = 3'd3,
    KIND_PSNP      = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ROLE_HEADER    = 3'd0,
    ROLE_FIXED     = 3'd1,
    ROLE_TLV_TYPE  = 3'd2,
    ROLE_TLV_LEN   = 3'd3,
    ROLE_TLV_VALUE = 3'd4,
    ROLE_IGNORED   = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_BUF_SHORT  = 3'd2,
    ST_TLV_OVERRUN = 3'd3,
    ST_STRAY_BYTE = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_HEADER  = 8'b0000_0010,
    PH_FIXED   = 8'b0000_0100,
    PH_TYPE    = 8'b0000_1000,
    PH_LEN     = 8'b0001_0000,
    PH_VALUE   = 8'b0010_0000,
    PH_OVERRUN = 8'b0100_0000,
    PH_AFTER   = 8'b1000_0000
  } phase_e;

  // One byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    kind_e       kind;
    logic [15:0] offset;
  } item_t;

  // Sizes of the fixed fields of each kind, in layout order; zero pads the row.
  localparam logic [15:0] FIELD_SIZES [NUM_KINDS][NUM_FIELDS] = '{
    '{16'd1, 16'(SYSTEM_ID_BYTES), 16'd2, 16'd1, 16'(LAN_ID_BYTES), 16'd0},
    '{16'd1, 16'(SYSTEM_ID_BYTES), 16'd2, 16'd1, 16'd0, 16'd0},
    '{16'd2, 16'd2, 16'(SYSTEM_ID_BYTES + 1), 16'd4, 16'd2, 16'd1},
    '{16'(SYSTEM_ID_BYTES), 16'(SYSTEM_ID_BYTES + 1), 16'(SYSTEM_ID_BYTES + 1),
      16'd0, 16'd0, 16'd0},
    '{16'(SYSTEM_ID_BYTES), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  // Offset of the first byte after the fixed fields.
  function automatic logic [15:0] fixed_end(kind_e kind);
    logic [15:0] res;
    unique case (kind)
      KIND_LAN_HELLO: res = 16'(COMMON_HDR_LEN + 1 + SYSTEM_ID_BYTES + 2 + 1 + LAN_ID_BYTES);
      KIND_P2P_HELLO: res = 16'(COMMON_HDR_LEN + 1 + SYSTEM_ID_BYTES + 2 + 1);
      KIND_LSP:       res = 16'(COMMON_HDR_LEN + 2 + 2 + SYSTEM_ID_BYTES + 1 + 4 + 2 + 1);
      KIND_CSNP:      res = 16'(COMMON_HDR_LEN + 3 * SYSTEM_ID_BYTES + 2);
      default:        res = 16'(COMMON_HDR_LEN + SYSTEM_ID_BYTES);
    endcase
    return res;
  endfunction

  // Number of the fixed field that holds byte pos of the fixed part.
  function automatic logic [3:0] field_at(kind_e kind, logic [15:0] pos);
    logic [15:0] limit;
    logic        found;
    logic [3:0]  idx;
    limit = '0;
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      limit = limit + FIELD_SIZES[kind][i];
      if (!found && pos < limit) begin
        found = 1'b1;
        idx   = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/rpbp_front.sv =====
// Front end: accepts bytes, tracks the offset and kind, and queues them.
module rpbp_front import rpbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       buffer_end_i,
  input  logic [2:0] pdu_kind_i,
  input  logic       full_i,
  output logic       push_o,
  output item_t      push_item_o
);

  logic [15:0] offset_q, offset_d;
  kind_e       kind_q, kind_d;
  logic [15:0] off;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    off    = first_byte_i ? '0 : offset_q;
    kind_d = kind_q;
    if (first_byte_i) begin
      kind_d = (pdu_kind_i > 3'(KIND_PSNP)) ? KIND_PSNP : kind_e'(pdu_kind_i);
    end
    offset_d = (off == 16'hFFFF) ? off : off + 16'd1;
  end

  assign push_item_o = '{data: data_byte_i, first: first_byte_i, last: buffer_end_i,
                         kind: kind_d, offset: off};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      kind_q   <= KIND_LAN_HELLO;
    end else if (push_o) begin
      offset_q <= offset_d;
      kind_q   <= kind_d;
    end
  end

endmodule

// ===== rtl/core/rpbp_queue.sv =====
// Short first-in first-out queue between the front and the back.
module rpbp_queue import rpbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rpbp_back.sv =====
// Back end: walks the PDU layout and TLVs, and registers one result per byte.
module rpbp_back import rpbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  item_t       head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_role_o,
  output logic [3:0]  field_index_o,
  output logic [15:0] byte_offset_o,
  output logic [7:0]  tlv_type_o,
  output logic [7:0]  tlv_length_o,
  output logic        pdu_done_o,
  output logic [2:0]  status_o
);

  phase_e      phase_q, phase_d, ph;
  logic [15:0] pdu_end_q, pdu_end_d, pend;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  high_q, high_d;

  logic        out_valid_q;
  role_e       role_q, role;
  logic [3:0]  fidx_q, fidx;
  logic [15:0] off_q;
  logic [7:0]  tt_q, tt, tl_q, tl;
  logic        done_q, done;
  status_e     st_q, st;

  logic [15:0] off;
  logic [16:0] off_next;
  logic [16:0] diff;
  logic [15:0] left;
  logic [15:0] fend;
  logic [15:0] known;
  logic        is_lsp;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    off      = head_i.offset;
    off_next = {1'b0, off} + 17'd1;
    is_lsp   = (head_i.kind == KIND_LSP);
    fend     = fixed_end(head_i.kind);
    known    = is_lsp ? 16'd9 : 16'd7;

    // A first byte opens a fresh PDU before anything else is looked at.
    ph     = head_i.first ? PH_HEADER : phase_q;
    pend   = head_i.first ? '0 : pdu_end_q;
    rem_d  = head_i.first ? '0 : rem_q;
    type_d = head_i.first ? '0 : type_q;
    len_d  = head_i.first ? '0 : len_q;
    high_d = head_i.first ? '0 : high_q;

    pdu_end_d = pend;
    phase_d   = ph;
    role      = ROLE_IGNORED;
    fidx      = '0;
    tt        = '0;
    tl        = '0;
    done      = 1'b0;
    st        = ST_OK;

    diff = {1'b0, pend} - off_next;
    left = ({1'b0, pend} > off_next) ? diff[15:0] : '0;

    unique case (ph)
      PH_HEADER: begin
        role = ROLE_HEADER;
        fidx = {1'b0, off[2:0]};
        if (!is_lsp && off == 16'd1) begin
          pdu_end_d = {8'd0, head_i.data};
        end
        if (off >= 16'd7) begin
          if (!is_lsp && pdu_end_d <= 16'(COMMON_HDR_LEN)) begin
            done = 1'b1;
            st   = ST_BAD_LENGTH;
          end else begin
            phase_d = PH_FIXED;
          end
        end
      end
      PH_FIXED: begin
        role = ROLE_FIXED;
        fidx = field_at(head_i.kind, off - 16'(COMMON_HDR_LEN));
        if (is_lsp && off == 16'd8) begin
          high_d = head_i.data;
        end
        if (is_lsp && off == 16'd9) begin
          pdu_end_d = {high_d, head_i.data};
        end
        if (off >= known && off_next >= {1'b0, pdu_end_d}) begin
          done = 1'b1;
          st   = (off_next == {1'b0, fend} && pdu_end_d == fend) ? ST_OK : ST_BAD_LENGTH;
        end else if (off_next >= {1'b0, fend}) begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        role   = ROLE_TLV_TYPE;
        tt     = head_i.data;
        type_d = head_i.data;
        len_d  = '0;
        if (off_next >= {1'b0, pend}) begin
          done = 1'b1;
          st   = ST_STRAY_BYTE;
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        role  = ROLE_TLV_LEN;
        tt    = type_d;
        tl    = head_i.data;
        len_d = head_i.data;
        if ({8'd0, head_i.data} > left) begin
          if (left == '0) begin
            done = 1'b1;
            st   = ST_TLV_OVERRUN;
          end else begin
            phase_d = PH_OVERRUN;
          end
        end else if (head_i.data == '0) begin
          if (left == '0) begin
            done = 1'b1;
            st   = ST_OK;
          end else begin
            phase_d = PH_TYPE;
          end
        end else begin
          rem_d   = head_i.data;
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        role = ROLE_TLV_VALUE;
        tt   = type_d;
        tl   = len_d;
        if (rem_d != '0) begin
          rem_d = rem_d - 8'd1;
        end
        if (off_next >= {1'b0, pend}) begin
          done = 1'b1;
          st   = ST_OK;
        end else if (rem_d == '0) begin
          phase_d = PH_TYPE;
        end
      end
      PH_OVERRUN: begin
        role = ROLE_TLV_VALUE;
        tt   = type_d;
        tl   = len_d;
        if (off_next >= {1'b0, pend}) begin
          done = 1'b1;
          st   = ST_TLV_OVERRUN;
        end
      end
      PH_IDLE, PH_AFTER: begin
        role = ROLE_IGNORED;
      end
      default: begin
        role = ROLE_IGNORED;
      end
    endcase

    if (done) begin
      phase_d = PH_AFTER;
    end
    if (head_i.last) begin
      if (!done && phase_d != PH_IDLE && phase_d != PH_AFTER) begin
        done = 1'b1;
        st   = ST_BUF_SHORT;
      end
      phase_d = PH_IDLE;
    end
    if (!done) begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pdu_end_q   <= '0;
      rem_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      pdu_end_q   <= pdu_end_d;
      rem_q       <= rem_d;
      type_q      <= type_d;
      len_q       <= len_d;
      high_q      <= high_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      role_q <= role;
      fidx_q <= fidx;
      off_q  <= off;
      tt_q   <= tt;
      tl_q   <= tl;
      done_q <= done;
      st_q   <= st;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_role_o   = role_q;
  assign field_index_o = fidx_q;
  assign byte_offset_o = off_q;
  assign tlv_type_o    = tt_q;
  assign tlv_length_o  = tl_q;
  assign pdu_done_o    = done_q;
  assign status_o      = st_q;

endmodule

// ===== rtl/core/routing_pdu_byte_parser.sv =====
// Top level of the IS-IS PDU byte parser: front end, queue and back end.
//
// The block takes an IS-IS PDU one byte per item on the input channel
// (in_valid_i / in_stall_o) and gives one result item per byte on the output
// channel (out_valid_o / out_stall_i). An item moves at a rising edge where
// valid is high and stall is low. first_byte_i opens a new PDU, and the kind
// is sampled with it; buffer_end_i marks the last byte of the buffer.
// Each result tags its byte as header, fixed field, TLV type, length, value
// or ignored, with its offset, the current TLV type and length, and, on the
// byte that settles it, the PDU verdict with a status.
// The front end keeps the offset and kind and pushes each byte into a
// four-entry queue; the back end walks the layout and writes one output
// register. Each accepted byte passes through the queue and then the output
// register, and one byte is taken and delivered every cycle for as long as
// both sides keep moving: the walk needs only one counter and compare update
// per byte in the back end.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_stall_o rises once the queue is full.
// Reset empties the queue and the output register and returns the walker to
// idle with offset, kind and all lengths at zero.
module routing_pdu_byte_parser import rpbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        buffer_end_i,
  input  logic [2:0]  pdu_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_role_o,
  output logic [3:0]  field_index_o,
  output logic [15:0] byte_offset_o,
  output logic [7:0]  tlv_type_o,
  output logic [7:0]  tlv_length_o,
  output logic        pdu_done_o,
  output logic [2:0]  status_o
);

  logic  push, full, head_valid, pop;
  item_t push_item, head_item;

  // The front end only counts offsets and latches the kind, so it waits only
  // when the queue is full.
  rpbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .first_byte_i(first_byte_i),
    .buffer_end_i(buffer_end_i),
    .pdu_kind_i  (pdu_kind_i),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  rpbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .valid_o(head_valid),
    .item_o (head_item),
    .pop_i  (pop)
  );

  // The back end takes a queued byte whenever its output register is free
  // or being emptied in the same cycle.
  rpbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_role_o  (byte_role_o),
    .field_index_o(field_index_o),
    .byte_offset_o(byte_offset_o),
    .tlv_type_o   (tlv_type_o),
    .tlv_length_o (tlv_length_o),
    .pdu_done_o   (pdu_done_o),
    .status_o     (status_o)
  );

endmodule

// ===== rtl/core/rpbp_checker.sv =====
// Port-level checks on the IS-IS PDU byte parser, bound to its top level.
module rpbp_checker import rpbp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        first_byte_i,
  input logic        buffer_end_i,
  input logic [2:0]  pdu_kind_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  byte_role_o,
  input logic [3:0]  field_index_o,
  input logic [15:0] byte_offset_o,
  input logic [7:0]  tlv_type_o,
  input logic [7:0]  tlv_length_o,
  input logic        pdu_done_o,
  input logic [2:0]  status_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Status is only reported together with a verdict.
  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pdu_done_o |-> status_o == 3'(ST_OK))
    else $error("status without verdict");

  // A byte outside any open PDU carries no verdict and no TLV context.
  a_ignored_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_role_o == 3'(ROLE_IGNORED)
      |-> !pdu_done_o && tlv_type_o == '0 && tlv_length_o == '0 && field_index_o == '0)
    else $error("ignored byte with context");

  // Header bytes are numbered by their offset from the PDU start.
  a_header_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_role_o == 3'(ROLE_HEADER)
      |-> byte_offset_o == {12'd0, field_index_o} && field_index_o < 4'd8)
    else $error("header byte index does not match offset");

  // A type byte has no declared length yet.
  a_type_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_role_o == 3'(ROLE_TLV_TYPE)
      |-> tlv_length_o == '0 && tlv_type_o == tlv_type_o)
    else $error("type byte with a length");

endmodule

bind routing_pdu_byte_parser rpbp_checker u_rpbp_checker (.*);

// ===== bench/routing_pdu_byte_parser_tb.sv =====
// Self-checking testbench for the IS-IS PDU byte parser.
`timescale 1ns / 100ps

module routing_pdu_byte_parser_tb import rpbp_pkg::*;;

  // A kind code outside the five named kinds; the parser walks it as a PSNP.
  localparam logic [2:0] KIND_OUT_OF_RANGE = 3'd7;

  // Content shapes that the PDU builder can produce.
  typedef enum {SHAPE_GOOD, SHAPE_BAD_LEN, SHAPE_OVERRUN, SHAPE_STRAY} pdu_shape_e;
  // How a built PDU is handed over: whole, with the buffer ending early, or
  // cut short by the next first byte.
  typedef enum {SEND_WHOLE, SEND_SHORT, SEND_CUT} delivery_e;

  typedef logic [7:0] octet_q_t[$];

  // What the parser should report for one byte.
  typedef struct {
    role_e       role;
    logic [3:0]  fidx;
    logic [15:0] off;
    logic [7:0]  tlv_type;
    logic [7:0]  tlv_len;
    logic        done;
    status_e     status;
  } byte_tag_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        buffer_end_i = 1'b0;
  logic [2:0]  pdu_kind_i = 3'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  byte_role_o;
  logic [3:0]  field_index_o;
  logic [15:0] byte_offset_o;
  logic [7:0]  tlv_type_o;
  logic [7:0]  tlv_length_o;
  logic        pdu_done_o;
  logic [2:0]  status_o;

  routing_pdu_byte_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .buffer_end_i  (buffer_end_i),
    .pdu_kind_i    (pdu_kind_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_role_o   (byte_role_o),
    .field_index_o (field_index_o),
    .byte_offset_o (byte_offset_o),
    .tlv_type_o    (tlv_type_o),
    .tlv_length_o  (tlv_length_o),
    .pdu_done_o    (pdu_done_o),
    .status_o      (status_o)
  );

  // Tags still owed by the parser, oldest first.
  byte_tag_t pending_tags[$];
  int        mismatches = 0;
  // Items accepted that the parser should walk, i.e. not tag as ignored.
  int        walked_items = 0;
  // Chance, in percent, that the sender holds back an item or the receiver
  // stalls in a given cycle.
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // Our own copy of the walker's state.
  logic [15:0] walk_pos = '0;
  logic [15:0] walk_end = '0;
  kind_e       walk_kind = KIND_LAN_HELLO;
  phase_e      walk_phase = PH_IDLE;
  logic [7:0]  tlv_left = '0;
  logic [7:0]  tlv_type_q = '0;
  logic [7:0]  tlv_len_q = '0;
  logic [7:0]  len_high = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Safety net: a hung handshake or a lost result ends the run here.
  initial begin
    #40ms;
    $display("routing_pdu_byte_parser verification failed");
    $finish;
  end

  // Size of fixed field i of a kind's layout; zero past the last field.
  function automatic int layout_field(kind_e k, int i);
    int sz[6];
    case (k)
      KIND_LAN_HELLO: sz = '{1, SYSTEM_ID_BYTES, 2, 1, LAN_ID_BYTES, 0};
      KIND_P2P_HELLO: sz = '{1, SYSTEM_ID_BYTES, 2, 1, 0, 0};
      KIND_LSP:       sz = '{2, 2, SYSTEM_ID_BYTES + 1, 4, 2, 1};
      KIND_CSNP:      sz = '{SYSTEM_ID_BYTES, SYSTEM_ID_BYTES + 1, SYSTEM_ID_BYTES + 1,
                             0, 0, 0};
      default:        sz = '{SYSTEM_ID_BYTES, 0, 0, 0, 0, 0};
    endcase
    return sz[i];
  endfunction

  function automatic int fixed_len(kind_e k);
    int sum;
    sum = 0;
    for (int i = 0; i < 6; i++) sum += layout_field(k, i);
    return sum;
  endfunction

  function automatic int field_index(kind_e k, int pos);
    int s;
    for (int i = 0; i < 6; i++) begin
      s = layout_field(k, i);
      if (pos < s) return i;
      pos -= s;
    end
    return 0;
  endfunction

  // Advances our copy of the walker by one byte and returns the tag the
  // parser should give it.
  function automatic byte_tag_t tag_byte(logic [7:0] d, logic fb, logic be, logic [2:0] pk);
    byte_tag_t t;
    int        off, pend, fend, known, left;
    logic      done;
    status_e   st;
    t.role = ROLE_IGNORED;
    t.fidx = '0;
    t.tlv_type = '0;
    t.tlv_len = '0;
    done = 1'b0;
    st = ST_OK;
    if (fb) begin
      walk_pos = '0;
      walk_kind = (pk > 3'd4) ? KIND_PSNP : kind_e'(pk);
      walk_phase = PH_HEADER;
      tlv_left = '0;
      tlv_type_q = '0;
      tlv_len_q = '0;
      len_high = '0;
      walk_end = '0;
    end
    off = walk_pos;
    fend = COMMON_HDR_LEN + fixed_len(walk_kind);
    known = (walk_kind == KIND_LSP) ? 9 : 7;
    case (walk_phase)
      PH_HEADER: begin
        t.role = ROLE_HEADER;
        t.fidx = 4'(off & 7);
        if (walk_kind != KIND_LSP && off == 1) walk_end = {8'h00, d};
        if (off >= 7) begin
          if (walk_kind != KIND_LSP && walk_end <= 16'd8) begin
            done = 1'b1;
            st = ST_BAD_LENGTH;
          end else begin
            walk_phase = PH_FIXED;
          end
        end
      end
      PH_FIXED: begin
        t.role = ROLE_FIXED;
        t.fidx = 4'(field_index(walk_kind, off - COMMON_HDR_LEN));
        if (walk_kind == KIND_LSP && off == 8) len_high = d;
        if (walk_kind == KIND_LSP && off == 9) walk_end = {len_high, d};
        pend = walk_end;
        if (off >= known && off + 1 >= pend) begin
          done = 1'b1;
          st = (off + 1 == fend && pend == fend) ? ST_OK : ST_BAD_LENGTH;
        end else if (off + 1 >= fend) begin
          walk_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        t.role = ROLE_TLV_TYPE;
        t.tlv_type = d;
        tlv_type_q = d;
        tlv_len_q = '0;
        if (off + 1 >= int'(walk_end)) begin
          done = 1'b1;
          st = ST_STRAY_BYTE;
        end else begin
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        pend = walk_end;
        left = (pend > off + 1) ? pend - off - 1 : 0;
        t.role = ROLE_TLV_LEN;
        t.tlv_type = tlv_type_q;
        t.tlv_len = d;
        tlv_len_q = d;
        if (int'(d) > left) begin
          // The value cannot fit: either the PDU ends right here or the rest
          // of it is swallowed as value bytes.
          if (left == 0) begin
            done = 1'b1;
            st = ST_TLV_OVERRUN;
          end else begin
            walk_phase = PH_OVERRUN;
          end
        end else if (d == 8'd0) begin
          if (left == 0) done = 1'b1;
          else walk_phase = PH_TYPE;
        end else begin
          tlv_left = d;
          walk_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        t.role = ROLE_TLV_VALUE;
        t.tlv_type = tlv_type_q;
        t.tlv_len = tlv_len_q;
        if (tlv_left > 8'd0) tlv_left--;
        if (off + 1 >= int'(walk_end)) done = 1'b1;
        else if (tlv_left == 8'd0) walk_phase = PH_TYPE;
      end
      PH_OVERRUN: begin
        t.role = ROLE_TLV_VALUE;
        t.tlv_type = tlv_type_q;
        t.tlv_len = tlv_len_q;
        if (off + 1 >= int'(walk_end)) begin
          done = 1'b1;
          st = ST_TLV_OVERRUN;
        end
      end
      default: ;
    endcase
    if (done) walk_phase = PH_AFTER;
    // The buffer ending with a PDU still open settles it as short.
    if (be) begin
      if (!done && walk_phase != PH_IDLE && walk_phase != PH_AFTER) begin
        done = 1'b1;
        st = ST_BUF_SHORT;
      end
      walk_phase = PH_IDLE;
    end
    t.off = 16'(off);
    t.done = done;
    t.status = done ? st : ST_OK;
    walk_pos = (off < 65535) ? 16'(off + 1) : 16'hFFFF;
    return t;
  endfunction

  // Builds one PDU: random header and fixed fields, the length field set from
  // the shape, a TLV walk of area bytes, and up to three bytes past max(length, 10).
  function automatic octet_q_t build_pdu(kind_e k, pdu_shape_e shape, int area, int tlv_max);
    octet_q_t body;
    int       fend, plen, pos, rem, len, maxl, extra, n;
    fend = COMMON_HDR_LEN + fixed_len(k);
    extra = 0;
    // A single leftover byte would be a stray type byte, so never leave one.
    if (area == 1) area = 2;
    case (shape)
      SHAPE_BAD_LEN: plen = $urandom_range(0, fend - 1);
      SHAPE_STRAY:   plen = fend + area + 1;
      SHAPE_OVERRUN: begin
        extra = $urandom_range(2, 10);
        plen = fend + area + extra;
      end
      default:       plen = fend + area;
    endcase
    n = ((plen > 10) ? plen : 10) + $urandom_range(0, 3);
    for (int i = 0; i < n; i++) body = {body, 8'($urandom_range(0, 255))};
    if (k == KIND_LSP) begin
      body[8] = 8'(plen >> 8);
      body[9] = 8'(plen);
    end else begin
      body[1] = 8'(plen);
    end
    if (shape != SHAPE_BAD_LEN) begin
      pos = fend;
      rem = area;
      while (rem > 0) begin
        maxl = (rem - 2 < tlv_max) ? rem - 2 : tlv_max;
        len = $urandom_range(0, maxl);
        if (rem - 2 - len == 1) len = (len < maxl) ? len + 1 : len - 1;
        body[pos + 1] = 8'(len);
        pos += 2 + len;
        rem -= 2 + len;
      end
      // The last TLV declares more value bytes than the PDU has left.
      if (shape == SHAPE_OVERRUN) body[pos + 1] = 8'($urandom_range(extra - 1, 255));
    end
    return body;
  endfunction

  // Hands one item to the parser and records the tag it should produce.
  task automatic send_byte(input logic [7:0] d, input logic fb, input logic be,
                           input logic [2:0] pk);
    logic      taken;
    byte_tag_t tag;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    first_byte_i <= fb;
    buffer_end_i <= be;
    pdu_kind_i   <= pk;
    // Stall is read mid-cycle, where it is settled for the coming edge.
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    tag = tag_byte(d, fb, be, pk);
    pending_tags = {pending_tags, tag};
    if (tag.role != ROLE_IGNORED) walked_items++;
  endtask

  // Sends random PDUs of one shape and delivery until budget walked items
  // have gone in. Short and cut deliveries mix all shapes.
  task automatic send_pdus(input pdu_shape_e shape, input delivery_e how, input int budget);
    int         goal, last;
    logic [2:0] pk;
    kind_e      k;
    pdu_shape_e s;
    logic       with_end;
    octet_q_t   body;
    goal = walked_items + budget;
    while (walked_items < goal) begin
      // Now and then a stray item with no PDU open.
      if ($urandom_range(0, 9) == 0)
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                  3'($urandom_range(0, 7)));
      pk = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      k = (pk > 3'd4) ? KIND_PSNP : kind_e'(pk);
      s = (how == SEND_WHOLE) ? shape : pdu_shape_e'($urandom_range(0, 3));
      body = build_pdu(k, s, $urandom_range(0, 40), 12);
      last = body.size() - 1;
      with_end = ($urandom_range(0, 9) != 0);
      if (how == SEND_SHORT) begin
        last = $urandom_range(0, body.size() - 2);
        with_end = 1'b1;
      end else if (how == SEND_CUT) begin
        last = $urandom_range(0, body.size() - 2);
        with_end = 1'b0;
      end
      for (int i = 0; i <= last; i++)
        send_byte(body[i], i == 0, with_end && i == last,
                  (i == 0) ? pk : 3'($urandom_range(0, 7)));
    end
  endtask

  // Items outside any PDU, a zero length on an out-of-range kind settled on
  // the buffer's last byte, and a minimal PSNP closed by an empty TLV.
  task automatic test_directed();
    logic [7:0] d;
    send_byte(8'h00, 1'b0, 1'b0, KIND_LAN_HELLO);
    send_byte(8'hFF, 1'b0, 1'b1, KIND_OUT_OF_RANGE);
    for (int i = 0; i < 8; i++)
      send_byte((i == 1) ? 8'h00 : 8'hFF, i == 0, i == 7, KIND_OUT_OF_RANGE);
    for (int i = 0; i < 16; i++) begin
      d = (i % 2 == 0) ? 8'h00 : 8'hA5;
      if (i == 1) d = 8'd16;
      if (i == 14) d = 8'hFF;
      if (i == 15) d = 8'h00;
      send_byte(d, i == 0, i == 15, KIND_PSNP);
    end
  endtask

  task automatic test_well_formed(input int budget);
    send_pdus(SHAPE_GOOD, SEND_WHOLE, budget);
  endtask

  task automatic test_bad_length(input int budget);
    send_pdus(SHAPE_BAD_LEN, SEND_WHOLE, budget);
  endtask

  task automatic test_tlv_overrun(input int budget);
    send_pdus(SHAPE_OVERRUN, SEND_WHOLE, budget);
  endtask

  task automatic test_stray_byte(input int budget);
    send_pdus(SHAPE_STRAY, SEND_WHOLE, budget);
  endtask

  task automatic test_buffer_short(input int budget);
    send_pdus(SHAPE_GOOD, SEND_SHORT, budget);
  endtask

  task automatic test_restart(input int budget);
    send_pdus(SHAPE_GOOD, SEND_CUT, budget);
  endtask

  // The receiver stalls at random, at the rate of the current stage.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Outputs are sampled mid-cycle; a result with valid high and stall low
  // here is taken at the next edge.
  always @(negedge clk_i) begin : result_check
    byte_tag_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_tags.size() == 0) begin
        $display("%0t: result with no item pending, expected none, actual offset %0d",
                 $time, byte_offset_o);
        mismatches++;
      end else begin
        want = pending_tags.pop_front();
        compare_field("byte_role", want.role, byte_role_o);
        compare_field("field_index", want.fidx, field_index_o);
        compare_field("byte_offset", want.off, byte_offset_o);
        compare_field("tlv_type", want.tlv_type, tlv_type_o);
        compare_field("tlv_length", want.tlv_len, tlv_length_o);
        compare_field("pdu_done", want.done, pdu_done_o);
        compare_field("status", want.status, status_o);
      end
    end
  end

  // Three stages of idling: a slow receiver, then a slow sender, then full
  // rate with no gaps at all.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 6 : (stage == 1) ? 76 : 0;
      recv_idle_pct = (stage == 0) ? 76 : (stage == 1) ? 6 : 0;
      if (stage == 0) test_directed();
      test_well_formed(60);
      test_bad_length(10);
      test_tlv_overrun(10);
      test_stray_byte(10);
      test_buffer_short(10);
      test_restart(10);
    end
    in_valid_i <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    // A few more cycles to catch any result the parser should not give.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("routing_pdu_byte_parser verification clean");
    else
      $display("routing_pdu_byte_parser verification failed");
    $finish;
  end

endmodule
